// ----- hdl/uudecode_line_decoder_top_defines.svh -----
// Assertion macros for the uudecode line decoder.
// Included by the top level; relies on clk_i and rst_ni being in scope.
`ifndef UUDECODE_LINE_DECODER_TOP_DEFINES_SVH
`define UUDECODE_LINE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UUDL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UUDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/uudl_pkg.sv -----
// Shared types and constants of the uudecode line decoder.
// Used by the front, the queue, the back and the top level.
package uudl_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] CapacityReset = 8'd255;
  localparam logic [7:0] CharFirst     = 8'h21;  // '!'
  localparam logic [7:0] CharBackquote = 8'h60;  // '`', also the last valid char
  localparam logic [7:0] CharOffset    = 8'd32;

  localparam logic [1:0] StatusGood  = 2'd0;
  localparam logic [1:0] StatusEof   = 2'd1;
  localparam logic [1:0] StatusError = 2'd2;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Work for the back end: an optional data byte followed by an optional status.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       has_status;
    logic [1:0] status;
    logic [5:0] length;
  } rec_t;

endpackage

// ----- hdl/uudl_front.sv -----
// Front end: tracks line state and turns each character into a result record.
// Depends on uudl_pkg.
module uudl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          line_char_i,
  input  logic                line_end_i,
  input  logic [7:0]          capacity_i,
  output logic                push_o,
  output uudl_pkg::rec_t      rec_o
);

  localparam logic [2:0] PhLength = 3'd0;
  localparam logic [2:0] PhGroup  = 3'd1;
  localparam logic [2:0] PhDone   = 3'd2;
  localparam logic [2:0] PhEof    = 3'd3;
  localparam logic [2:0] PhError  = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic [5:0] expected_q, expected_d;
  logic [5:0] produced_q, produced_d;
  logic [1:0] gpos_q, gpos_d;
  logic [5:0] held_q, held_d;

  logic       char_ok;
  logic [7:0] char_off;
  logic [5:0] six;
  logic [5:0] produced_inc;
  logic       emit_ok;
  uudl_pkg::rec_t rec;

  assign char_ok      = (line_char_i >= uudl_pkg::CharFirst) &&
                        (line_char_i <= uudl_pkg::CharBackquote);
  assign char_off     = line_char_i - uudl_pkg::CharOffset;
  assign six          = char_off[5:0];
  assign emit_ok      = produced_q < expected_q;
  assign produced_inc = produced_q + 6'd1;

  always_comb begin
    phase_d    = phase_q;
    expected_d = expected_q;
    produced_d = produced_q;
    gpos_d     = gpos_q;
    held_d     = held_q;
    rec        = '0;

    unique case (phase_q)
      PhLength: begin
        if (line_char_i == uudl_pkg::CharBackquote) begin
          phase_d = PhEof;
        end else if (!char_ok || ({2'b00, six} > capacity_i)) begin
          phase_d = PhError;
        end else begin
          expected_d = six;
          produced_d = '0;
          gpos_d     = '0;
          phase_d    = PhGroup;
        end
      end
      PhGroup: begin
        if (!char_ok) begin
          phase_d = PhError;
        end else begin
          unique case (gpos_q)
            2'd0: gpos_d = 2'd1;
            2'd1: begin
              rec.data_byte = {held_q, six[5:4]};
              gpos_d        = 2'd2;
            end
            2'd2: begin
              rec.data_byte = {held_q[3:0], six[5:2]};
              gpos_d        = 2'd3;
            end
            default: begin
              rec.data_byte = {held_q[1:0], six};
              gpos_d        = 2'd0;
            end
          endcase
          // only bytes the count asks for leave the block
          if (gpos_q != 2'd0 && emit_ok) begin
            rec.has_byte = 1'b1;
            produced_d   = produced_inc;
          end
          if (gpos_q == 2'd3 && produced_d >= expected_q) begin
            phase_d = PhDone;
          end
          held_d = six;
        end
      end
      default: ;
    endcase

    if (!rec.has_byte) begin
      rec.data_byte = '0;
    end

    if (line_end_i) begin
      rec.has_status = 1'b1;
      priority if (phase_d == PhDone) begin
        rec.status = uudl_pkg::StatusGood;
        rec.length = expected_d;
      end else if (phase_d == PhEof) begin
        rec.status = uudl_pkg::StatusEof;
      end else begin
        rec.status = uudl_pkg::StatusError;
      end
      phase_d    = PhLength;
      expected_d = '0;
      produced_d = '0;
      gpos_d     = '0;
      held_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhLength;
      expected_q <= '0;
      produced_q <= '0;
      gpos_q     <= '0;
      held_q     <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      expected_q <= expected_d;
      produced_q <= produced_d;
      gpos_q     <= gpos_d;
      held_q     <= held_d;
    end
  end

  assign push_o = accept_i && (rec.has_byte || rec.has_status);
  assign rec_o  = rec;

endmodule

// ----- hdl/uudl_queue.sv -----
// Short register queue of result records between front and back.
// Depends on uudl_pkg.
module uudl_queue #(
  parameter int unsigned Depth = uudl_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  uudl_pkg::rec_t             push_rec_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output uudl_pkg::rec_t             head_o,
  output logic                       full_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  uudl_pkg::rec_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  assign valid_o = count_q != '0;
  assign full_o  = count_q == CntW'(Depth);
  assign head_o  = slots_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ----- hdl/uudl_back.sv -----
// Back end: holds one record and hands out its byte, then its status.
// Depends on uudl_pkg.
module uudl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  uudl_pkg::rec_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           out_kind_o,
  output logic [15:0]    out_data_o,
  output logic           out_last_o
);

  uudl_pkg::rec_t cur_q, cur_d;
  logic show_byte, last_piece, out_fire, pop;

  assign show_byte   = cur_q.has_byte;
  assign out_valid_o = cur_q.has_byte || cur_q.has_status;
  assign last_piece  = !(cur_q.has_byte && cur_q.has_status);
  assign out_fire    = out_valid_o && out_ready_i;
  assign pop         = q_valid_i && (!out_valid_o || (out_fire && last_piece));

  always_comb begin
    cur_d = cur_q;
    if (pop) begin
      cur_d = q_head_i;
    end else if (out_fire) begin
      // drop the piece just taken
      cur_d.has_byte = 1'b0;
      if (last_piece) begin
        cur_d.has_status = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

  assign q_pop_o    = pop;
  assign out_kind_o = show_byte ? uudl_pkg::KindData : uudl_pkg::KindStatus;
  assign out_last_o = !show_byte;
  assign out_data_o = show_byte ? {6'd0, 2'd0, cur_q.data_byte}
                                : {cur_q.length, cur_q.status, 8'd0};

endmodule

// ----- hdl/uudecode_line_decoder_top.sv -----
// Top level of the uudecode line decoder: stream ports, APB register, assertions.
// Depends on uudl_pkg, uudl_front, uudl_queue, uudl_back and the defines header.
//
//   channel   dir  tdata                         tuser  tlast
//   s_axis    in   line_char                     -      line_end
//   m_axis    out  data_byte, status, length     kind   last
//   apb       in   out_capacity at byte addr 0   -      -
//
// One character is taken per cycle while the result queue has room.
// The output side moves one result per cycle while m_axis_tready is high: a character that
// gives a byte and a status yields two results there; the queue (QueueDepth records) absorbs them.
// An accepted character's record is registered in the queue, then in the back end's record register.
// Reset is asynchronous and clears line state, queue and output; no clearing pass.
`include "uudecode_line_decoder_top_defines.svh"

module uudecode_line_decoder_top #(
  parameter int unsigned QueueDepth = uudl_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] line_char
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status, [15:10] decoded_length
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic RegCapacity = 1'b0;

  logic [7:0] capacity_q;
  logic       in_accept;
  logic       push, pop, q_valid, q_full;
  logic [$clog2(QueueDepth+1)-1:0] q_count;
  uudl_pkg::rec_t push_rec, head_rec;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= uudl_pkg::CapacityReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegCapacity)) begin
      capacity_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == RegCapacity) ? {24'd0, capacity_q} : 32'd0;

  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  uudl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .line_char_i (s_axis_tdata),
    .line_end_i  (s_axis_tlast),
    .capacity_i  (capacity_q),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  uudl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_rec),
    .full_o     (q_full),
    .count_o    (q_count)
  );

  uudl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head_rec),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  `UUDL_ASSERT_NOW(a_status_is_last,
                   m_axis_tvalid && (m_axis_tuser == uudl_pkg::KindStatus),
                   m_axis_tlast && (m_axis_tdata[7:0] == 8'd0),
                   "status result without tlast or with byte bits")
  `UUDL_ASSERT_NOW(a_byte_not_last,
                   m_axis_tvalid && (m_axis_tuser == uudl_pkg::KindData),
                   !m_axis_tlast && (m_axis_tdata[15:8] == 8'd0),
                   "data result with tlast or status bits")
  `UUDL_ASSERT_NEXT(a_line_end_queued,
                    in_accept && s_axis_tlast,
                    q_count != '0,
                    "line end did not queue a status")

endmodule
